[rtl/core/uer_pkg.sv]
package uer_pkg;

    localparam int SENSOR_COUNT = 3;
    localparam int SENSOR_W     = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    localparam int CMD_W    = 2;
    localparam int SEL_W    = 2;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int DIST_W   = 11;
    localparam int IVAL_W   = 16;

    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    localparam logic [PADDR_W-1:0] REG_TRIGGER_INTERVAL = 2'd0;
    localparam logic [IVAL_W-1:0]  INTERVAL_RESET       = 16'd30;

    // width / 58 as multiply by ceil(2^21 / 58), exact for any 16-bit width
    localparam logic [16:0] DIV58_RECIP = 17'd36158;
    localparam int          DIV58_SHIFT = 21;
    localparam int          CM_DIVISOR  = 58;
    localparam int          DIST_MAX    = 1129;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TIME_W-1:0]  now_ms;
        logic [SEL_W-1:0]   sensor;
        logic [COUNT_W-1:0] capture_count;
    } item_t;

    typedef struct packed {
        logic              trigger_fire;
        logic [SEL_W-1:0]  fire_sensor;
    } trig_res_t;

    typedef struct packed {
        logic               measure_done;
        logic [COUNT_W-1:0] echo_width_us;
        logic [DIST_W-1:0]  distance_cm;
    } echo_res_t;

    typedef struct packed {
        logic               trigger_fire;
        logic [SEL_W-1:0]   fire_sensor;
        logic               measure_done;
        logic [COUNT_W-1:0] echo_width_us;
        logic [DIST_W-1:0]  distance_cm;
    } result_t;

    function automatic logic [DIST_W-1:0] div58(input logic [COUNT_W-1:0] w);
        logic [32:0] prod;
        prod = {17'b0, w} * {16'b0, DIV58_RECIP};
        return prod[DIV58_SHIFT +: DIST_W];
    endfunction

endpackage

[rtl/core/ultrasonic_echo_ranger_unit.sv]
// Ultrasonic echo ranger for a small set of sensors.
// Input channel (s_valid/s_ready) carries one command item: a millisecond
// tick, an echo capture edge with its timer count, or a distance read.
// Result channel (m_valid/m_ready) returns exactly one item per command:
// trigger request for ticks, measurement flag plus stored width and
// distance for captures and reads.
// An accepted item is held in the input register, then in the result
// register. Throughput: one item per cycle while m_ready does not stall,
// set by the single combinational step between the two registers; the
// per-sensor state is read and written in that one step.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; s_ready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages, clears all sensor
// state, the trigger time and round-robin pointer, and sets the trigger
// interval to 30 ms. The APB port writes the interval; write it only while
// no items are in flight.
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic [SEL_W-1:0]   s_sensor,
    input  logic [COUNT_W-1:0] s_capture_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_trigger_fire,
    output logic [SEL_W-1:0]   m_fire_sensor,
    output logic               m_measure_done,
    output logic [COUNT_W-1:0] m_echo_width_us,
    output logic [DIST_W-1:0]  m_distance_cm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    item_t             in_item_reg;
    logic              in_valid_reg;
    result_t           out_res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              process;
    logic [IVAL_W-1:0] trigger_interval;
    trig_res_t         trig_res;
    echo_res_t         echo_res;
    result_t           res_next;

    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    uer_apb_regs u_regs (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .trigger_interval (trigger_interval)
    );

    uer_trigger u_trigger (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item             (in_item_reg),
        .process          (process),
        .trigger_interval (trigger_interval),
        .res              (trig_res)
    );

    uer_echo u_echo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .process (process),
        .res     (echo_res)
    );

    // each unit drives zeros for commands it does not own
    always_comb begin
        res_next.trigger_fire  = trig_res.trigger_fire;
        res_next.fire_sensor   = trig_res.fire_sensor;
        res_next.measure_done  = echo_res.measure_done;
        res_next.echo_width_us = echo_res.echo_width_us;
        res_next.distance_cm   = echo_res.distance_cm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.cmd           <= s_cmd;
            in_item_reg.now_ms        <= s_now_ms;
            in_item_reg.sensor        <= s_sensor;
            in_item_reg.capture_count <= s_capture_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_trigger_fire   = out_res_reg.trigger_fire;
    assign m_fire_sensor    = out_res_reg.fire_sensor;
    assign m_measure_done   = out_res_reg.measure_done;
    assign m_echo_width_us  = out_res_reg.echo_width_us;
    assign m_distance_cm    = out_res_reg.distance_cm;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stage stalled while result stage could move");

    a_trigger_excludes_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trigger_fire) |-> (!m_measure_done && m_echo_width_us == '0))
        else $error("tick result carries echo fields");

    a_distance_matches_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_measure_done) |->
        ((32'(m_distance_cm) * CM_DIVISOR <= 32'(m_echo_width_us)) &&
         (32'(m_echo_width_us) < 32'(m_distance_cm) * CM_DIVISOR + CM_DIVISOR)))
        else $error("distance is not width divided by 58");

    a_distance_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_distance_cm) <= DIST_MAX))
        else $error("distance out of range");
`endif

endmodule

[rtl/core/uer_apb_regs.sv]
module uer_apb_regs import uer_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [IVAL_W-1:0]  trigger_interval
);

    logic [IVAL_W-1:0] interval_reg;
    logic [IVAL_W-1:0] interval_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        interval_next = interval_reg;
        prdata        = '0;
        unique case (paddr)
            REG_TRIGGER_INTERVAL: begin
                prdata = {{(PDATA_W-IVAL_W){1'b0}}, interval_reg};
                if (wr_en) begin
                    interval_next = pwdata[IVAL_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else begin
            interval_reg <= interval_next;
        end
    end

    assign trigger_interval = interval_reg;

endmodule

[rtl/core/uer_trigger.sv]
module uer_trigger import uer_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  item_t             item,
    input  logic              process,
    input  logic [IVAL_W-1:0] trigger_interval,
    output trig_res_t         res
);

    logic [TIME_W-1:0]   last_reg;
    logic [TIME_W-1:0]   last_next;
    logic [SENSOR_W-1:0] next_sensor_reg;
    logic [SENSOR_W-1:0] next_sensor_next;
    logic [TIME_W-1:0]   elapsed;
    logic                due;

    assign elapsed = item.now_ms - last_reg;
    assign due     = (item.cmd == CMD_TICK) &&
                     (elapsed >= {{(TIME_W-IVAL_W){1'b0}}, trigger_interval});

    always_comb begin
        last_next        = last_reg;
        next_sensor_next = next_sensor_reg;
        res              = '0;
        if (due) begin
            res.trigger_fire = 1'b1;
            res.fire_sensor  = SEL_W'(next_sensor_reg);
            last_next        = item.now_ms;
            // advance round robin, wrap after the last sensor
            if (next_sensor_reg == SENSOR_W'(SENSOR_COUNT - 1)) begin
                next_sensor_next = '0;
            end else begin
                next_sensor_next = next_sensor_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg        <= '0;
            next_sensor_reg <= '0;
        end else if (process) begin
            last_reg        <= last_next;
            next_sensor_reg <= next_sensor_next;
        end
    end

endmodule

[rtl/core/uer_echo.sv]
module uer_echo import uer_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  item_t     item,
    input  logic      process,
    output echo_res_t res
);

    logic               phase_reg [SENSOR_COUNT];
    logic [COUNT_W-1:0] rise_reg  [SENSOR_COUNT];
    logic [COUNT_W-1:0] width_reg [SENSOR_COUNT];
    logic [DIST_W-1:0]  dist_reg  [SENSOR_COUNT];

    logic [SENSOR_COUNT-1:0] hit;
    logic                    is_capture;
    logic                    sel_phase;
    logic [COUNT_W-1:0]      sel_rise;
    logic [COUNT_W-1:0]      sel_width;
    logic [DIST_W-1:0]       sel_dist;
    logic [COUNT_W-1:0]      new_width;
    logic [DIST_W-1:0]       new_dist;
    logic                    falling;

    assign is_capture = (item.cmd == CMD_CAPTURE);

    always_comb begin
        sel_phase = 1'b0;
        sel_rise  = '0;
        sel_width = '0;
        sel_dist  = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            hit[i] = ((item.cmd == CMD_CAPTURE) || (item.cmd == CMD_READ)) &&
                     ({2'b0, item.sensor} == 4'(i));
            if (hit[i]) begin
                sel_phase = phase_reg[i];
                sel_rise  = rise_reg[i];
                sel_width = width_reg[i];
                sel_dist  = dist_reg[i];
            end
        end
    end

    assign falling   = is_capture && (|hit) && sel_phase;
    assign new_width = item.capture_count - sel_rise;
    assign new_dist  = div58(new_width);

    always_comb begin
        res = '0;
        if (|hit) begin
            if (falling) begin
                res.measure_done  = 1'b1;
                res.echo_width_us = new_width;
                res.distance_cm   = new_dist;
            end else begin
                res.echo_width_us = sel_width;
                res.distance_cm   = sel_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                phase_reg[i] <= 1'b0;
                rise_reg[i]  <= '0;
                width_reg[i] <= '0;
                dist_reg[i]  <= '0;
            end
        end else if (process && is_capture) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (hit[i]) begin
                    if (!phase_reg[i]) begin
                        rise_reg[i]  <= item.capture_count;
                        phase_reg[i] <= 1'b1;
                    end else begin
                        width_reg[i] <= new_width;
                        dist_reg[i]  <= new_dist;
                        phase_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
module testbench import uer_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [SEL_W-1:0]  NO_SENSOR   = 2'd3;
    localparam logic [IVAL_W-1:0] IVAL_MAX    = '1;
    localparam int                CYCLE_LIMIT = 200000;
    localparam int                PHASE_ITEMS = 180;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd;
    logic [TIME_W-1:0]  s_now_ms;
    logic [SEL_W-1:0]   s_sensor;
    logic [COUNT_W-1:0] s_capture_count;
    logic               m_valid;
    logic               m_ready;
    logic               m_trigger_fire;
    logic [SEL_W-1:0]   m_fire_sensor;
    logic               m_measure_done;
    logic [COUNT_W-1:0] m_echo_width_us;
    logic [DIST_W-1:0]  m_distance_cm;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // ranging state as the block should hold it
    logic               in_pulse  [SENSOR_COUNT];
    logic [COUNT_W-1:0] rise_at   [SENSOR_COUNT];
    logic [COUNT_W-1:0] width_mem [SENSOR_COUNT];
    logic [DIST_W-1:0]  dist_mem  [SENSOR_COUNT];
    logic [TIME_W-1:0]  last_fire_ms;
    int                 rr_sensor;
    logic [IVAL_W-1:0]  interval_ms;

    result_t            awaited_results[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    logic [TIME_W-1:0]  sim_ms;
    bit                 src_idle_on = 1'b0;
    bit                 sink_idle_on = 1'b0;
    int                 hold_left = 0;

    ultrasonic_echo_ranger_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_now_ms        (s_now_ms),
        .s_sensor        (s_sensor),
        .s_capture_count (s_capture_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trigger_fire  (m_trigger_fire),
        .m_fire_sensor   (m_fire_sensor),
        .m_measure_done  (m_measure_done),
        .m_echo_width_us (m_echo_width_us),
        .m_distance_cm   (m_distance_cm),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t next_ranger_result(input item_t it);
        result_t            r;
        logic [TIME_W-1:0]  since;
        logic [COUNT_W-1:0] w;
        int                 idx;
        r = '0;
        idx = int'(it.sensor);
        case (it.cmd)
            CMD_TICK: begin
                since = it.now_ms - last_fire_ms;
                if (since >= {16'b0, interval_ms}) begin
                    r.trigger_fire = 1'b1;
                    r.fire_sensor = SEL_W'(rr_sensor);
                    rr_sensor = (rr_sensor + 1) % SENSOR_COUNT;
                    last_fire_ms = it.now_ms;
                end
            end
            CMD_CAPTURE, CMD_READ: begin
                // out-of-range sensor: no update, all-zero result
                if (idx < SENSOR_COUNT) begin
                    if (it.cmd == CMD_CAPTURE) begin
                        if (!in_pulse[idx]) begin
                            rise_at[idx] = it.capture_count;
                            in_pulse[idx] = 1'b1;
                        end else begin
                            w = it.capture_count - rise_at[idx];
                            width_mem[idx] = w;
                            dist_mem[idx] = DIST_W'(int'(w) / CM_DIVISOR);
                            in_pulse[idx] = 1'b0;
                            r.measure_done = 1'b1;
                        end
                    end
                    r.echo_width_us = width_mem[idx];
                    r.distance_cm = dist_mem[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic item_t echo_item(input logic [CMD_W-1:0] cmd,
                                        input logic [TIME_W-1:0] now,
                                        input logic [SEL_W-1:0] sensor,
                                        input logic [COUNT_W-1:0] count);
        item_t it;
        it.cmd = cmd;
        it.now_ms = now;
        it.sensor = sensor;
        it.capture_count = count;
        return it;
    endfunction

    // Mostly captures and ticks on a running clock, plus reads, with some noise.
    function automatic item_t random_item(input logic [IVAL_W-1:0] ival);
        item_t it;
        int    pick;
        it.now_ms = $urandom();
        it.sensor = SEL_W'($urandom_range(0, 3));
        it.capture_count = COUNT_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.cmd = CMD_TICK;
            if ($urandom_range(0, 9) == 0)
                sim_ms = $urandom();
            else
                sim_ms = sim_ms + $urandom_range(0, 2 * int'(ival) + 2);
            it.now_ms = sim_ms;
        end else if (pick < 75) begin
            it.cmd = CMD_CAPTURE;
            it.sensor = ($urandom_range(0, 19) == 0) ? NO_SENSOR : SEL_W'($urandom_range(0, 2));
        end else if (pick < 95) begin
            it.cmd = CMD_READ;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // Enter and leave at a falling edge.
    task automatic push_item(input item_t it);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_now_ms <= it.now_ms;
        s_sensor <= it.sensor;
        s_capture_count <= it.capture_count;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(next_ranger_result(it));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_interval(input logic [IVAL_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_TRIGGER_INTERVAL;
        pwdata <= PDATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        interval_ms = val;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_after_reset();
        push_item(echo_item(CMD_READ, 32'd0, 2'd0, 16'd0));
        push_item(echo_item(CMD_READ, '1, 2'd1, '1));
        push_item(echo_item(CMD_READ, 32'd5, 2'd2, 16'd7));
        push_item(echo_item(CMD_READ, 32'd5, NO_SENSOR, 16'd7));
        push_item(echo_item(CMD_UNUSED, '1, 2'd1, '1));
        push_item(echo_item(CMD_TICK, 32'd0, 2'd0, 16'd0));
        push_item(echo_item(CMD_TICK, 32'd29, 2'd0, 16'd0));
        push_item(echo_item(CMD_TICK, 32'd30, 2'd0, 16'd0));
    endtask

    task automatic test_echo_capture();
        // falling count below rising count: width wraps
        push_item(echo_item(CMD_CAPTURE, 32'd0, 2'd0, 16'hFFF0));
        push_item(echo_item(CMD_CAPTURE, 32'd0, 2'd0, 16'h0010));
        push_item(echo_item(CMD_CAPTURE, '1, 2'd1, 16'h0000));
        push_item(echo_item(CMD_CAPTURE, '1, 2'd1, 16'hFFFF));
        push_item(echo_item(CMD_CAPTURE, 32'd0, 2'd2, 16'h1234));
        push_item(echo_item(CMD_CAPTURE, 32'd0, 2'd2, 16'h1234 + 16'd116));
        push_item(echo_item(CMD_CAPTURE, 32'd0, NO_SENSOR, 16'h4321));
        push_item(echo_item(CMD_READ, 32'd0, 2'd1, 16'd0));
    endtask

    task automatic test_tick_wrap();
        push_item(echo_item(CMD_TICK, 32'hFFFF_FFFF, 2'd3, 16'hFFFF));
        push_item(echo_item(CMD_TICK, 32'd10, 2'd0, 16'd0));
        push_item(echo_item(CMD_TICK, 32'd29, 2'd0, 16'd0));
        push_item(echo_item(CMD_TICK, 32'd60, 2'd0, 16'd0));
    endtask

    task automatic test_interval_settings();
        drain_results();
        write_interval(16'd0);
        push_item(echo_item(CMD_TICK, 32'd60, 2'd0, 16'd0));
        drain_results();
        write_interval(IVAL_MAX);
        push_item(echo_item(CMD_TICK, 32'd60 + 32'd65534, 2'd0, 16'd0));
        push_item(echo_item(CMD_TICK, 32'd60 + 32'd65535, 2'd0, 16'd0));
        drain_results();
        write_interval(16'd1);
        push_item(echo_item(CMD_TICK, 32'd60 + 32'd65536, 2'd0, 16'd0));
        drain_results();
        write_interval(INTERVAL_RESET);
    endtask

    task automatic test_result_backpressure();
        int n;
        bit src_was;
        src_was = src_idle_on;
        src_idle_on = 1'b0;
        sim_ms = last_fire_ms;
        hold_left = 60;
        for (n = 0; n < 16; n++)
            push_item(random_item(interval_ms));
        src_idle_on = src_was;
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [IVAL_W-1:0] phase_ival [5];
        int                phase;
        int                n;
        phase_ival[0] = IVAL_W'($urandom_range(2, 200));
        phase_ival[1] = 16'd1;
        phase_ival[2] = IVAL_MAX;
        phase_ival[3] = 16'd0;
        phase_ival[4] = INTERVAL_RESET;
        for (phase = 0; phase < 5; phase++) begin
            drain_results();
            write_interval(phase_ival[phase]);
            sim_ms = last_fire_ms;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 4) begin
                    src_idle_on = 1'b0;
                    sink_idle_on = 1'b0;
                end else if (n % 30 == 0) begin
                    src_idle_on = ($urandom_range(0, 3) != 0);
                    sink_idle_on = ($urandom_range(0, 3) != 0);
                end
                push_item(random_item(interval_ms));
            end
        end
    endtask

    // Result side: random stall bursts plus a requested long hold.
    initial begin : sink_side
        int gap_left;
        gap_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with no item pending");
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("trigger_fire", 32'(want.trigger_fire), 32'(m_trigger_fire));
                check_field("fire_sensor", 32'(want.fire_sensor), 32'(m_fire_sensor));
                check_field("measure_done", 32'(want.measure_done), 32'(m_measure_done));
                check_field("echo_width_us", 32'(want.echo_width_us),
                            32'(m_echo_width_us));
                check_field("distance_cm", 32'(want.distance_cm), 32'(m_distance_cm));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : run_tests
        int i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = CMD_TICK;
        s_now_ms = '0;
        s_sensor = '0;
        s_capture_count = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_TRIGGER_INTERVAL;
        pwdata = '0;
        for (i = 0; i < SENSOR_COUNT; i++) begin
            in_pulse[i] = 1'b0;
            rise_at[i] = '0;
            width_mem[i] = '0;
            dist_mem[i] = '0;
        end
        last_fire_ms = '0;
        rr_sensor = 0;
        interval_ms = INTERVAL_RESET;
        sim_ms = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;

        test_after_reset();
        test_echo_capture();
        test_tick_wrap();
        test_interval_settings();
        test_result_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/uer_pkg.sv
rtl/core/uer_apb_regs.sv
rtl/core/uer_trigger.sv
rtl/core/uer_echo.sv
rtl/core/ultrasonic_echo_ranger_unit.sv
tb/testbench.sv
